/* rtl/core/dbt_pkg.sv */
// Shared types and constants of the double binary tree neighbor lookup.
// No dependencies; every module of the block uses this package.
package dbt_pkg;

  localparam int unsigned NodeW  = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned NbW    = 11;
  localparam int unsigned InW    = 16;
  localparam int unsigned OutW   = 72;

  localparam logic [CountW-1:0] MaxRanks = 11'd1024;
  localparam logic [NbW-1:0]    NoNode   = '1;

  typedef logic [NbW-1:0] nb_t;

  typedef struct packed {
    logic             st1;
    logic             st2;
    logic             st3;
    logic             st4;
  } pipe_en_t;

  typedef struct packed {
    logic              err;
    logic [CountW-1:0] n;
    logic [NodeW-1:0]  r0;
    logic [NodeW-1:0]  d0;
    logic [NodeW-1:0]  r1;
    logic [NodeW-1:0]  d1;
  } prep_t;

  typedef struct packed {
    nb_t up;
    nb_t lo;
    nb_t hi;
  } links_t;

  // Status ends up in the lowest bit of the packed word.
  typedef struct packed {
    nb_t  second_right_child;
    nb_t  second_left_child;
    nb_t  second_parent;
    nb_t  first_right_child;
    nb_t  first_left_child;
    nb_t  first_parent;
    logic status;
  } result_t;

  localparam int unsigned ResW = $bits(result_t);

endpackage

/* rtl/core/dbt_prep.sv */
// First stage: count saturation, range check and rank of the second tree.
// Depends on dbt_pkg.
module dbt_prep (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [dbt_pkg::NodeW-1:0] node_index_i,
  input  logic [dbt_pkg::CountW-1:0] node_count_i,
  output dbt_pkg::prep_t            prep_o
);

  dbt_pkg::prep_t              prep_d, prep_q;
  logic [dbt_pkg::CountW-1:0]  nsat;
  logic [dbt_pkg::CountW-1:0]  nm1;
  logic [dbt_pkg::NodeW-1:0]   r1;

  always_comb begin
    nsat = (node_count_i > dbt_pkg::MaxRanks) ? dbt_pkg::MaxRanks : node_count_i;
    nm1  = nsat - 11'd1;
    if (nsat[0]) begin
      r1 = (node_index_i == '0) ? nm1[dbt_pkg::NodeW-1:0] : node_index_i - 10'd1;
    end else begin
      r1 = nm1[dbt_pkg::NodeW-1:0] - node_index_i;
    end
    prep_d.err = (nsat == '0) || ({1'b0, node_index_i} >= nsat);
    prep_d.n   = nsat;
    prep_d.r0  = node_index_i;
    prep_d.d0  = nm1[dbt_pkg::NodeW-1:0] - node_index_i;
    prep_d.r1  = r1;
    prep_d.d1  = nm1[dbt_pkg::NodeW-1:0] - r1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

/* rtl/core/dbt_tree.sv */
// Parent and children of one rank in one binary tree, over two stages.
// Depends on dbt_pkg.
module dbt_tree (
  input  logic                       clk_i,
  input  logic                       en2_i,
  input  logic                       en3_i,
  input  logic [dbt_pkg::CountW-1:0] n_i,
  input  logic [dbt_pkg::NodeW-1:0]  r_i,
  input  logic [dbt_pkg::NodeW-1:0]  d_i,
  output dbt_pkg::links_t            links_o
);

  logic [dbt_pkg::NodeW-1:0] bit_w, half, sm, msbd, p_d, p_q, r_q, rx;
  dbt_pkg::nb_t              upc, up_d, up_q, lo_d, lo_q;
  dbt_pkg::links_t           links_d, links_q;

  always_comb begin
    bit_w = r_i & (~r_i + 10'd1);
    half  = bit_w >> 1;
    sm    = d_i | (d_i >> 1);
    sm    = sm | (sm >> 2);
    sm    = sm | (sm >> 4);
    sm    = sm | (sm >> 8);
    msbd  = sm ^ (sm >> 1);
    rx    = r_i ^ bit_w;
    upc   = {1'b0, rx} | {bit_w, 1'b0};
    if (r_i == '0) begin
      p_d  = msbd;
      up_d = dbt_pkg::NoNode;
      lo_d = dbt_pkg::NoNode;
    end else begin
      p_d  = (half <= d_i) ? half : msbd;
      up_d = (upc >= n_i) ? {1'b0, rx} : upc;
      lo_d = (half == '0) ? dbt_pkg::NoNode : {1'b0, r_i - half};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      p_q  <= p_d;
      r_q  <= r_i;
      up_q <= up_d;
      lo_q <= lo_d;
    end
  end

  always_comb begin
    links_d.up = up_q;
    links_d.lo = lo_q;
    links_d.hi = (p_q == '0) ? dbt_pkg::NoNode : ({1'b0, r_q} + {1'b0, p_q});
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      links_q <= links_d;
    end
  end

  assign links_o = links_q;

endmodule

/* rtl/core/dbt_map.sv */
// Last stage: second tree back to rank space, error forcing, result register.
// Depends on dbt_pkg.
module dbt_map (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       err_i,
  input  logic [dbt_pkg::CountW-1:0] n_i,
  input  dbt_pkg::links_t            t0_i,
  input  dbt_pkg::links_t            t1_i,
  output dbt_pkg::result_t           res_o
);

  dbt_pkg::result_t res_d, res_q;

  function automatic dbt_pkg::nb_t map_back(input logic [dbt_pkg::CountW-1:0] n,
                                            input dbt_pkg::nb_t v);
    dbt_pkg::nb_t inc;
    inc = v + 11'd1;
    if (v == dbt_pkg::NoNode) begin
      return dbt_pkg::NoNode;
    end else if (n[0]) begin
      return (inc == n) ? '0 : inc;
    end else begin
      return n - 11'd1 - v;
    end
  endfunction

  always_comb begin
    if (err_i) begin
      res_d.status             = 1'b1;
      res_d.first_parent       = dbt_pkg::NoNode;
      res_d.first_left_child   = dbt_pkg::NoNode;
      res_d.first_right_child  = dbt_pkg::NoNode;
      res_d.second_parent      = dbt_pkg::NoNode;
      res_d.second_left_child  = dbt_pkg::NoNode;
      res_d.second_right_child = dbt_pkg::NoNode;
    end else begin
      res_d.status             = 1'b0;
      res_d.first_parent       = t0_i.up;
      res_d.first_left_child   = t0_i.lo;
      res_d.first_right_child  = t0_i.hi;
      res_d.second_parent      = map_back(n_i, t1_i.up);
      res_d.second_left_child  = map_back(n_i, t1_i.lo);
      res_d.second_right_child = map_back(n_i, t1_i.hi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/core/double_binary_tree_neighbors.sv */
// Double binary tree neighbor lookup: parent and children of a rank in two trees.
// Four register stages from request accept to result valid: prep, tree, tree, map.
// Throughput: one request per cycle; the pipeline advances whenever its last stage
// is empty or the result is taken, so a stall loses nothing.
// Reset: clears all stage valid bits and sets node_count to 1.
// Depends on dbt_pkg, dbt_prep, dbt_tree and dbt_map.
module double_binary_tree_neighbors (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dbt_pkg::CountW-1:0]  cfg_wdata_i,   // node_count
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dbt_pkg::InW-1:0]     s_axis_tdata,  // node_index, zero pad
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status, first_parent, first_left_child, first_right_child, second_parent,
  // second_left_child, second_right_child, zero pad
  output logic [dbt_pkg::OutW-1:0]    m_axis_tdata
);

  logic [dbt_pkg::CountW-1:0] node_count_q;
  logic [3:0]                 valid_q;
  dbt_pkg::pipe_en_t          en;
  dbt_pkg::prep_t             prep;
  logic                       err2_q, err3_q;
  logic [dbt_pkg::CountW-1:0] n2_q, n3_q;
  dbt_pkg::links_t            t0, t1;
  dbt_pkg::result_t           res;

  always_comb begin
    en.st4 = !valid_q[3] || m_axis_tready;
    en.st3 = !valid_q[2] || en.st4;
    en.st2 = !valid_q[1] || en.st3;
    en.st1 = !valid_q[0] || en.st2;
  end

  assign s_axis_tready = en.st1;
  assign m_axis_tvalid = valid_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd1;
      valid_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (en.st1) valid_q[0] <= s_axis_tvalid;
      if (en.st2) valid_q[1] <= valid_q[0];
      if (en.st3) valid_q[2] <= valid_q[1];
      if (en.st4) valid_q[3] <= valid_q[2];
    end
  end

  dbt_prep u_prep (
    .clk_i        (clk_i),
    .en_i         (en.st1),
    .node_index_i (s_axis_tdata[dbt_pkg::NodeW-1:0]),
    .node_count_i (node_count_q),
    .prep_o       (prep)
  );

  always_ff @(posedge clk_i) begin
    if (en.st2) begin
      err2_q <= prep.err;
      n2_q   <= prep.n;
    end
    if (en.st3) begin
      err3_q <= err2_q;
      n3_q   <= n2_q;
    end
  end

  dbt_tree u_tree0 (
    .clk_i   (clk_i),
    .en2_i   (en.st2),
    .en3_i   (en.st3),
    .n_i     (prep.n),
    .r_i     (prep.r0),
    .d_i     (prep.d0),
    .links_o (t0)
  );

  dbt_tree u_tree1 (
    .clk_i   (clk_i),
    .en2_i   (en.st2),
    .en3_i   (en.st3),
    .n_i     (prep.n),
    .r_i     (prep.r1),
    .d_i     (prep.d1),
    .links_o (t1)
  );

  dbt_map u_map (
    .clk_i (clk_i),
    .en_i  (en.st4),
    .err_i (err3_q),
    .n_i   (n3_q),
    .t0_i  (t0),
    .t1_i  (t1),
    .res_o (res)
  );

  assign m_axis_tdata = {{(dbt_pkg::OutW - dbt_pkg::ResW){1'b0}}, res};

endmodule
